// File: rtl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Types and constants shared by the timer expiry queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  // opcodes of a request
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_POLL   = 2'd2,
    OP_QUERY  = 2'd3
  } tmq_op_t;

  // status codes of a result
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;

  // largest 48-bit time, also the infinite wait
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  // count of the last timer a single poll may fire (sixteen per poll)
  localparam logic [3:0] LAST_FIRE = 4'd15;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [31:0] interval_ms;
    logic        repeat_req;
    logic [15:0] task_tag;
    logic [47:0] now_ms;
  } tmq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [15:0] task_out;
    logic        last;
    logic        head_changed;
    logic        queue_empty;
    logic [47:0] next_wait_ms;
  } tmq_out_t;

  // classified request handed from front to back
  typedef struct packed {
    tmq_op_t     op;
    logic [3:0]  slot;
    logic        in_range;
    logic [31:0] interval_ms;
    logic        repeat_req;
    logic [15:0] task_tag;
    logic [47:0] now_ms;
  } tmq_cmd_t;

  // one timer slot as stored
  typedef struct packed {
    logic [47:0] expire;
    logic [31:0] period;
    logic        rep;
    logic [15:0] tag;
  } tmq_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } tmq_bstate_t;

  // now plus interval, saturated at the largest time
  function automatic logic [47:0] sat_add(input logic [47:0] now, input logic [31:0] ivl);
    logic [48:0] s;
    s = {1'b0, now} + {17'd0, ivl};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/tmq_front.sv
// ----------------------------------------------------------------------------
// tmq_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_front #(
  parameter int NUM_TIMERS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire tmq_pkg::tmq_in_t in_data,
  output logic                cmd_valid,
  input  wire                 cmd_pop,
  output tmq_pkg::tmq_cmd_t   cmd_data
);

  tmq_pkg::tmq_cmd_t q_r [2];
  logic              wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  tmq_pkg::tmq_cmd_t cls;
  logic              push, pop;

  // classify the incoming request
  always_comb begin
    cls.op          = tmq_pkg::tmq_op_t'(in_data.opcode);
    cls.slot        = in_data.slot;
    cls.in_range    = {28'd0, in_data.slot} < 32'(NUM_TIMERS);
    cls.interval_ms = in_data.interval_ms;
    cls.repeat_req  = in_data.repeat_req;
    cls.task_tag    = in_data.task_tag;
    cls.now_ms      = in_data.now_ms;
  end

  // two-entry request queue
  assign in_stall  = cnt_r == 2'd2;
  assign push      = in_valid && !in_stall;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop       = cmd_pop && cmd_valid;
  assign cmd_data  = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tmq_back.sv
// ----------------------------------------------------------------------------
// tmq_back
// Executes requests against the slot store with a one-slot-per-cycle scan.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_back #(
  parameter int NUM_TIMERS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cmd_valid,
  output logic                cmd_pop,
  input  wire tmq_pkg::tmq_cmd_t cmd_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output tmq_pkg::tmq_out_t   out_data
);

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  // slot store
  tmq_pkg::tmq_entry_t mem [NUM_TIMERS];
  tmq_pkg::tmq_entry_t rd_r, wd;
  logic                we;
  logic [SW-1:0]       wa;

  tmq_pkg::tmq_bstate_t st_r, st_nxt;
  tmq_pkg::tmq_cmd_t    cmd_r, cmd_nxt;
  logic [NUM_TIMERS-1:0] active_r, active_nxt, done_r, done_nxt;
  logic [47:0]          enew_r, enew_nxt, beste_r, beste_nxt;
  logic                 head_r, head_nxt, found_r, found_nxt, more_r, more_nxt;
  logic [SW-1:0]        best_r, best_nxt, pidx_r, pidx_nxt;
  logic [31:0]          bestp_r, bestp_nxt;
  logic                 bestrep_r, bestrep_nxt;
  logic [15:0]          besttag_r, besttag_nxt;
  logic [3:0]           nfire_r, nfire_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 iss_r, iss_nxt, pv_r, pv_nxt;
  tmq_pkg::tmq_out_t    res_r, res_nxt, out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [SW+3:0]        cext, sext;
  logic [SW-1:0]        cidx, sidx;
  logic [47:0]          e_sum, e_re;
  logic                 cand, out_free;

  assign cext = {{SW{1'b0}}, cmd_data.slot};
  assign cidx = cext[SW-1:0];
  assign sext = {{SW{1'b0}}, cmd_r.slot};
  assign sidx = sext[SW-1:0];
  assign e_sum = tmq_pkg::sat_add(cmd_data.now_ms, cmd_data.interval_ms);
  assign e_re  = tmq_pkg::sat_add(cmd_r.now_ms, bestp_r);

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cmd_pop   = (st_r == tmq_pkg::B_IDLE) && cmd_valid;

  // candidate test for the slot whose entry was read last cycle
  always_comb begin
    case (cmd_r.op)
      tmq_pkg::OP_POLL:  cand = active_r[pidx_r] && !done_r[pidx_r] &&
                                (rd_r.expire <= cmd_r.now_ms);
      tmq_pkg::OP_QUERY: cand = active_r[pidx_r];
      default:           cand = 1'b0;
    endcase
  end

  // sequencer: dispatch, scan, result hand-off
  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    active_nxt    = active_r;
    done_nxt      = done_r;
    enew_nxt      = enew_r;
    beste_nxt     = beste_r;
    head_nxt      = head_r;
    found_nxt     = found_r;
    more_nxt      = more_r;
    best_nxt      = best_r;
    pidx_nxt      = pidx_r;
    bestp_nxt     = bestp_r;
    bestrep_nxt   = bestrep_r;
    besttag_nxt   = besttag_r;
    nfire_nxt     = nfire_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    pv_nxt        = 1'b0;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    wa            = cidx;
    wd            = '{expire: e_sum, period: cmd_data.interval_ms,
                      rep: cmd_data.repeat_req, tag: cmd_data.task_tag};

    case (st_r)
      tmq_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd_data;
          res_nxt   = '0;
          res_nxt.status = tmq_pkg::ST_OK;
          res_nxt.last   = 1'b1;
          cnt_nxt   = '0;
          iss_nxt   = 1'b1;
          found_nxt = 1'b0;
          more_nxt  = 1'b0;
          st_nxt    = tmq_pkg::B_SCAN;
          case (cmd_data.op)
            tmq_pkg::OP_ADD: begin
              if (!cmd_data.in_range) begin
                res_nxt.status = tmq_pkg::ST_IDLE;
                st_nxt = tmq_pkg::B_EMIT;
              end else if (active_r[cidx]) begin
                res_nxt.status = tmq_pkg::ST_BUSY;
                st_nxt = tmq_pkg::B_EMIT;
              end else begin
                we               = 1'b1;
                active_nxt[cidx] = 1'b1;
                enew_nxt         = e_sum;
                head_nxt         = 1'b1;
              end
            end
            tmq_pkg::OP_CANCEL: begin
              if (!cmd_data.in_range || !active_r[cidx]) begin
                res_nxt.status = tmq_pkg::ST_IDLE;
              end else begin
                active_nxt[cidx] = 1'b0;
              end
              st_nxt = tmq_pkg::B_EMIT;
            end
            tmq_pkg::OP_POLL: begin
              done_nxt  = '0;
              nfire_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      tmq_pkg::B_SCAN: begin
        // issue the next slot read
        if (iss_r) begin
          pidx_nxt = cnt_r[SW-1:0];
          pv_nxt   = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
          iss_nxt  = cnt_r != CW'(NUM_TIMERS - 1);
        end
        // compare the entry read last cycle
        if (pv_r) begin
          if (cmd_r.op == tmq_pkg::OP_ADD) begin
            if (active_r[pidx_r] && (pidx_r != sidx) &&
                ((rd_r.expire < enew_r) ||
                 ((rd_r.expire == enew_r) && (pidx_r < sidx)))) begin
              head_nxt = 1'b0;
            end
          end else if (cand) begin
            if (found_r) begin
              more_nxt = 1'b1;
            end
            if (!found_r || (rd_r.expire < beste_r)) begin
              found_nxt   = 1'b1;
              best_nxt    = pidx_r;
              beste_nxt   = rd_r.expire;
              bestp_nxt   = rd_r.period;
              bestrep_nxt = rd_r.rep;
              besttag_nxt = rd_r.tag;
            end
          end
        end
        // scan done: form the result
        if (!iss_r && !pv_r) begin
          st_nxt = tmq_pkg::B_EMIT;
          case (cmd_r.op)
            tmq_pkg::OP_ADD: begin
              res_nxt.head_changed = head_r;
            end
            tmq_pkg::OP_QUERY: begin
              if (!found_r) begin
                res_nxt.queue_empty  = 1'b1;
                res_nxt.next_wait_ms = tmq_pkg::TIME_MAX;
              end else if (beste_r >= cmd_r.now_ms) begin
                res_nxt.next_wait_ms = beste_r - cmd_r.now_ms;
              end
            end
            tmq_pkg::OP_POLL: begin
              if (found_r) begin
                res_nxt.fired    = 1'b1;
                res_nxt.task_out = besttag_r;
                res_nxt.last     = !more_r || (nfire_r == tmq_pkg::LAST_FIRE);
                done_nxt[best_r] = 1'b1;
                nfire_nxt        = nfire_r + 4'd1;
                if (bestrep_r) begin
                  we = 1'b1;
                  wa = best_r;
                  wd = '{expire: e_re, period: bestp_r, rep: 1'b1, tag: besttag_r};
                end else begin
                  active_nxt[best_r] = 1'b0;
                end
              end else begin
                res_nxt.last = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      tmq_pkg::B_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if ((cmd_r.op == tmq_pkg::OP_POLL) && !res_r.last) begin
            res_nxt   = '0;
            cnt_nxt   = '0;
            iss_nxt   = 1'b1;
            found_nxt = 1'b0;
            more_nxt  = 1'b0;
            st_nxt    = tmq_pkg::B_SCAN;
          end else begin
            st_nxt = tmq_pkg::B_IDLE;
          end
        end
      end

      default: st_nxt = tmq_pkg::B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tmq_pkg::B_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      iss_r       <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    done_r    <= done_nxt;
    enew_r    <= enew_nxt;
    beste_r   <= beste_nxt;
    head_r    <= head_nxt;
    found_r   <= found_nxt;
    more_r    <= more_nxt;
    best_r    <= best_nxt;
    pidx_r    <= pidx_nxt;
    bestp_r   <= bestp_nxt;
    bestrep_r <= bestrep_nxt;
    besttag_r <= besttag_nxt;
    nfire_r   <= nfire_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // slot store: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[cnt_r[SW-1:0]];
  end

endmodule

`default_nettype wire

// File: rtl/timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Sorted timer queue: add, cancel, poll expired and query next wait.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are executed by a back end that walks
// the slot store one slot per cycle through its single read port. A cancel or
// a rejected add goes straight to its result with no scan; an accepted add, a
// query or a poll with nothing due takes one full pass over the slots; a poll
// takes one pass for every timer that it fires, since every fired timer is
// found by its own pass over the slots. A stalled result holds back the next
// result. Up to sixteen timers fire per poll, earliest first, lower slot first
// on ties.
`default_nettype none

module timer_expiry_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire tmq_pkg::tmq_in_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output tmq_pkg::tmq_out_t   out_data
);

  logic              cmd_valid, cmd_pop;
  tmq_pkg::tmq_cmd_t cmd_data;

  tmq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd_data (cmd_data)
  );

  tmq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd_data (cmd_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/tmq_checker.sv
// ----------------------------------------------------------------------------
// tmq_checker
// Port-level checks on the timer expiry queue result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               out_valid,
  input wire               out_stall,
  input wire tmq_pkg::tmq_out_t out_data
);

  // stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // a result without a fired timer always ends its request
  a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fired |-> out_data.last)
    else $error("non-fired result not last");

  // failed add or cancel reports no fired timer, head change or empty queue
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != tmq_pkg::ST_OK) |->
      !out_data.fired && !out_data.head_changed && !out_data.queue_empty)
    else $error("error result carries other fields");

endmodule

bind timer_expiry_queue tmq_checker u_tmq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

// File: bench/timer_expiry_queue_test.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue_test
// Drives add, cancel, poll and query requests into the timer queue with
// random gaps and output stalls, predicts every result from a private copy
// of the slot store and checks each result field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module timer_expiry_queue_test;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 200000;

  // scoreboard: timer store copy plus the queue of expected results
  class timer_scoreboard;
    bit                  active [SLOTS];
    logic [47:0]         expiry [SLOTS];
    logic [31:0]         ivl [SLOTS];
    bit                  rep [SLOTS];
    logic [15:0]         tag [SLOTS];
    tmq_pkg::tmq_out_t   pending [$];
    int                  errors;

    function automatic logic [47:0] arm_time(logic [47:0] now, logic [31:0] iv);
      logic [48:0] s;
      s = {1'b0, now} + {17'd0, iv};
      return s[48] ? tmq_pkg::TIME_MAX : s[47:0];
    endfunction

    function automatic bit earlier(int a, int b);
      if (expiry[a] != expiry[b]) return expiry[a] < expiry[b];
      return a < b;
    endfunction

    function automatic tmq_pkg::tmq_out_t blank();
      tmq_pkg::tmq_out_t r;
      r = '0;
      r.status = tmq_pkg::ST_OK;
      r.last = 1'b1;
      return r;
    endfunction

    // append one expected result
    function automatic void expect_result(tmq_pkg::tmq_out_t r);
      pending.insert(pending.size(), r);
    endfunction

    // work out the results of one accepted request
    function automatic void note_request(tmq_pkg::tmq_in_t rq);
      tmq_pkg::tmq_out_t r;
      bit due [SLOTS];
      bit head;
      int best, n;
      r = blank();
      case (tmq_pkg::tmq_op_t'(rq.opcode))
        tmq_pkg::OP_ADD: begin
          if (active[rq.slot]) begin
            r.status = tmq_pkg::ST_BUSY;
          end else begin
            active[rq.slot] = 1;
            ivl[rq.slot] = rq.interval_ms;
            rep[rq.slot] = rq.repeat_req;
            tag[rq.slot] = rq.task_tag;
            expiry[rq.slot] = arm_time(rq.now_ms, rq.interval_ms);
            head = 1;
            for (int i = 0; i < SLOTS; i++)
              if (i != rq.slot && active[i] && earlier(i, rq.slot)) head = 0;
            r.head_changed = head;
          end
          expect_result(r);
        end
        tmq_pkg::OP_CANCEL: begin
          if (!active[rq.slot]) r.status = tmq_pkg::ST_IDLE;
          else active[rq.slot] = 0;
          expect_result(r);
        end
        tmq_pkg::OP_POLL: begin
          n = 0;
          for (int i = 0; i < SLOTS; i++) due[i] = active[i] && expiry[i] <= rq.now_ms;
          while (n < SLOTS) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
              if (due[i] && (best < 0 || earlier(i, best))) best = i;
            if (best < 0) break;
            due[best] = 0;
            r = blank();
            r.last = 1'b0;
            r.fired = 1'b1;
            r.task_out = tag[best];
            expect_result(r);
            n++;
            if (rep[best]) expiry[best] = arm_time(rq.now_ms, ivl[best]);
            else active[best] = 0;
          end
          if (n == 0) expect_result(blank());
          else pending[$].last = 1'b1;
        end
        default: begin
          best = -1;
          for (int i = 0; i < SLOTS; i++)
            if (active[i] && (best < 0 || earlier(i, best))) best = i;
          if (best < 0) begin
            r.queue_empty = 1'b1;
            r.next_wait_ms = tmq_pkg::TIME_MAX;
          end else begin
            r.next_wait_ms = expiry[best] >= rq.now_ms ? expiry[best] - rq.now_ms : '0;
          end
          expect_result(r);
        end
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    function automatic void check_result(tmq_pkg::tmq_out_t got);
      tmq_pkg::tmq_out_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status)
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
      if (got.fired !== exp_r.fired)
        $display("%0t: fired exp %0d got %0d", $time, exp_r.fired, got.fired);
      if (got.task_out !== exp_r.task_out)
        $display("%0t: task_out exp %0h got %0h", $time, exp_r.task_out, got.task_out);
      if (got.last !== exp_r.last)
        $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
      if (got.head_changed !== exp_r.head_changed)
        $display("%0t: head_changed exp %0d got %0d", $time, exp_r.head_changed,
                 got.head_changed);
      if (got.queue_empty !== exp_r.queue_empty)
        $display("%0t: queue_empty exp %0d got %0d", $time, exp_r.queue_empty,
                 got.queue_empty);
      if (got.next_wait_ms !== exp_r.next_wait_ms)
        $display("%0t: next_wait_ms exp %0h got %0h", $time, exp_r.next_wait_ms,
                 got.next_wait_ms);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  tmq_pkg::tmq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tmq_pkg::tmq_out_t out_data;

  timer_scoreboard board = new();
  logic [47:0] clock_ms = 48'd1000;
  int          idle_cycles = 0;
  int          stall_left = 0;

  timer_expiry_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one, sometimes none
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: stall runs of random length, check accepted results
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 25) stall_left <= gap_len();
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timer_expiry_queue regression: fail");
      $finish;
    end
  end

  // send one request and wait until it is taken
  task automatic send_request(tmq_pkg::tmq_in_t rq);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    board.note_request(rq);
  endtask

  task automatic send_op(tmq_pkg::tmq_op_t op, int s, logic [31:0] iv, bit r,
                         logic [15:0] t, logic [47:0] now);
    tmq_pkg::tmq_in_t rq;
    rq.opcode = op;
    rq.slot = s[3:0];
    rq.interval_ms = iv;
    rq.repeat_req = r;
    rq.task_tag = t;
    rq.now_ms = now;
    send_request(rq);
  endtask

  function automatic logic [31:0] rand_interval();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 32'd0;
    if (p == 1) return 32'hFFFF_FFFF;
    if (p == 2) return $urandom();
    return $urandom_range(1, 60);
  endfunction

  initial begin
    tmq_pkg::tmq_in_t rq;
    int op_pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty query, poll of nothing, cancel of idle slot
    send_op(tmq_pkg::OP_QUERY, 0, 0, 0, 16'h0, 48'd0);
    send_op(tmq_pkg::OP_POLL, 0, 0, 0, 16'h0, 48'd0);
    send_op(tmq_pkg::OP_CANCEL, 15, 0, 0, 16'h0, 48'd0);
    // extremes and saturation near the top of time
    send_op(tmq_pkg::OP_ADD, 15, 32'hFFFF_FFFF, 1, 16'hFFFF, tmq_pkg::TIME_MAX);
    send_op(tmq_pkg::OP_ADD, 15, 32'd5, 0, 16'h1234, 48'd0);
    send_op(tmq_pkg::OP_QUERY, 0, 0, 0, 16'h0, 48'hFFFF_FFFF_FFF0);
    send_op(tmq_pkg::OP_ADD, 0, 32'd0, 1, 16'h0000, 48'd10);
    send_op(tmq_pkg::OP_ADD, 1, 32'd0, 0, 16'hA5A5, 48'd10);
    send_op(tmq_pkg::OP_QUERY, 0, 0, 0, 16'h0, 48'd20);
    // zero interval repeat refires only on the next poll
    send_op(tmq_pkg::OP_POLL, 0, 0, 0, 16'h0, 48'd10);
    send_op(tmq_pkg::OP_POLL, 0, 0, 0, 16'h0, 48'd10);
    send_op(tmq_pkg::OP_CANCEL, 0, 0, 0, 16'h0, 48'd10);
    send_op(tmq_pkg::OP_CANCEL, 15, 0, 0, 16'h0, 48'd10);
    // all slots due at once: sixteen fire, ties by slot
    for (int s = 0; s < SLOTS; s++)
      send_op(tmq_pkg::OP_ADD, s, 32'd3, s[0], 16'h100 + s[15:0], 48'd100);
    send_op(tmq_pkg::OP_POLL, 0, 0, 0, 16'h0, tmq_pkg::TIME_MAX);
    send_op(tmq_pkg::OP_POLL, 0, 0, 0, 16'h0, tmq_pkg::TIME_MAX);
    for (int s = 0; s < SLOTS; s += 2)
      send_op(tmq_pkg::OP_CANCEL, s, 0, 0, 16'h0, tmq_pkg::TIME_MAX);

    // random requests, time mostly moving forward
    for (int n = 0; n < 220; n++) begin
      clock_ms = clock_ms + $urandom_range(0, 30);
      op_pick = $urandom_range(0, 99);
      rq.opcode = op_pick < 40 ? tmq_pkg::OP_ADD : op_pick < 55 ? tmq_pkg::OP_CANCEL :
                  op_pick < 85 ? tmq_pkg::OP_POLL : tmq_pkg::OP_QUERY;
      rq.slot = 4'($urandom_range(0, SLOTS - 1));
      rq.interval_ms = rand_interval();
      rq.repeat_req = 1'($urandom_range(0, 1));
      rq.task_tag = 16'($urandom());
      rq.now_ms = ($urandom_range(0, 19) == 0) ? 48'({$urandom(), $urandom()}) : clock_ms;
      send_request(rq);
    end
    in_valid <= 1'b0;

    // drain, then allow a full poll pass worth of cycles
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.errors == 0) $display("timer_expiry_queue regression: pass");
    else $display("timer_expiry_queue regression: fail");
    $finish;
  end
endmodule

// File: filelist.f
rtl/tmq_pkg.sv
rtl/tmq_front.sv
rtl/tmq_back.sv
rtl/timer_expiry_queue.sv
rtl/tmq_checker.sv
bench/timer_expiry_queue_test.sv
